[rtl/ihex_pkg.sv]
// Shared types and constants of the HEX record loader.
// Used by ihex_ctrl, ihex_dpath, the top level and the checker; no dependencies.
package ihex_pkg;

    localparam int MAX_DATA     = 32;   // largest data field of a record, 1..32
    localparam int VECTOR_WORDS = 7;    // words covered by the vector checksum, 1..16

    localparam int BUF_AW  = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int VI_W    = (VECTOR_WORDS > 1) ? $clog2(VECTOR_WORDS) : 1;
    localparam int POS_W   = 6;         // record byte counter, saturates
    localparam int IDX_W   = 6;         // emit / sum index
    localparam int TDATA_W = 72;        // 32 + 32 + 3 packed, padded to bytes

    localparam logic [POS_W-1:0] POS_MAX  = '1;
    localparam logic [31:0]      VEC_ADDR = 32'(VECTOR_WORDS * 4);

    // record type byte codes
    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_EXT_SEG = 8'h02;
    localparam logic [7:0] REC_EXT_LIN = 8'h04;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_VEC    = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_DATA_OK   = 3'd0,
        ST_OTHER_OK  = 3'd1,
        ST_EOF       = 3'd2,
        ST_SUM_BAD   = 3'd3,
        ST_MALFORMED = 3'd4
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic    take;          // input transaction this cycle
        logic    judge;         // record complete: clear counters, latch base
        logic    set_offset;    // apply extended address record
        logic    idx_inc;
        logic    acc_add;
        logic    load_byte;
        logic    load_vec;
        logic    load_status;
        status_t status;
    } ihex_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       malformed;
        logic       sum_bad;
        logic [7:0] rec_type;
        logic       len_zero;
        logic       len_two;
        logic       byte_done;  // current index is the last data byte
        logic       vsum_done;  // current index is the last vector word
    } ihex_sts_t;

endpackage

[rtl/ihex_dpath.sv]
// Datapath of the HEX record loader: record fields, data buffer, offset,
// vector shadow with its adder, and the output register. Depends on ihex_pkg.
module ihex_dpath
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ihex_cmd_t   cmd,
    output ihex_sts_t   sts,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output kind_t       out_kind,
    output logic [31:0] out_addr,
    output logic [31:0] out_data,
    output status_t     out_status,
    output logic        out_last
);

    logic [POS_W-1:0] pos_reg;
    logic [7:0]       len_reg;
    logic [15:0]      raddr_reg;
    logic [7:0]       type_reg;
    logic [7:0]       sum_reg;
    logic [7:0]       d0_reg, d1_reg;
    logic [31:0]      offset_reg;
    logic [31:0]      base_reg;
    logic [31:0]      acc_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      shadow_reg [VECTOR_WORDS];

    logic [7:0]       buf_mem [MAX_DATA];
    logic [7:0]       rd_reg;

    kind_t            out_kind_reg;
    logic [31:0]      out_addr_reg;
    logic [31:0]      out_data_reg;
    status_t          out_status_reg;
    logic             out_last_reg;

    logic [POS_W-1:0] buf_wpos;
    logic             buf_we;
    logic [31:0]      byte_addr;
    logic             shadow_hit;
    logic [8:0]       total, expect_total;

    assign buf_wpos   = pos_reg - POS_W'(4);
    assign buf_we     = cmd.take && !in_last && (pos_reg >= POS_W'(4))
                        && (buf_wpos < POS_W'(MAX_DATA));
    assign idx_next   = cmd.judge ? '0 : (cmd.idx_inc ? idx_reg + IDX_W'(1) : idx_reg);
    assign byte_addr  = base_reg + 32'(idx_reg);
    assign shadow_hit = byte_addr[31:2] < 30'(VECTOR_WORDS);

    assign total        = 9'(pos_reg) + 9'd1;
    assign expect_total = 9'(len_reg) + 9'd5;

    assign out_kind   = out_kind_reg;
    assign out_addr   = out_addr_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    always_comb
    begin
        sts.malformed = (total != expect_total) || (len_reg > 8'(MAX_DATA));
        sts.sum_bad   = (sum_reg != 8'd0);
        sts.rec_type  = type_reg;
        sts.len_zero  = (len_reg == 8'd0);
        sts.len_two   = (len_reg == 8'd2);
        sts.byte_done = (9'(idx_reg) + 9'd1) == 9'(len_reg);
        sts.vsum_done = (idx_reg == IDX_W'(VECTOR_WORDS - 1));
    end

    // record buffer: one write port on input, one registered read port
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_wpos[BUF_AW-1:0]] <= in_byte;
        end
        rd_reg <= buf_mem[idx_next[BUF_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            raddr_reg  <= '0;
            type_reg   <= '0;
            sum_reg    <= '0;
            offset_reg <= '0;
            idx_reg    <= '0;
            for (int i = 0; i < VECTOR_WORDS; i++)
            begin
                shadow_reg[i] <= '0;
            end
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.take)
            begin
                sum_reg <= sum_reg + in_byte;
                if (!in_last)
                begin
                    unique case (pos_reg)
                        POS_W'(0): len_reg          <= in_byte;
                        POS_W'(1): raddr_reg[15:8]  <= in_byte;
                        POS_W'(2): raddr_reg[7:0]   <= in_byte;
                        POS_W'(3): type_reg         <= in_byte;
                        default:   ;
                    endcase
                    if (pos_reg != POS_MAX)
                    begin
                        pos_reg <= pos_reg + POS_W'(1);
                    end
                end
            end
            if (cmd.judge)
            begin
                pos_reg <= '0;
                sum_reg <= '0;
            end
            if (cmd.set_offset)
            begin
                if (type_reg == REC_EXT_SEG)
                begin
                    offset_reg <= {12'd0, d0_reg, d1_reg, 4'd0};
                end
                else
                begin
                    offset_reg <= {d0_reg, d1_reg, 16'd0};
                end
            end
            if (cmd.load_byte && shadow_hit)
            begin
                shadow_reg[byte_addr[VI_W+1:2]][{byte_addr[1:0], 3'b000} +: 8] <= rd_reg;
            end
        end
    end

    // payload, base, accumulator and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.take && !in_last && pos_reg == POS_W'(4))
        begin
            d0_reg <= in_byte;
        end
        if (cmd.take && !in_last && pos_reg == POS_W'(5))
        begin
            d1_reg <= in_byte;
        end
        if (cmd.judge)
        begin
            base_reg <= offset_reg + {16'd0, raddr_reg};
            acc_reg  <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + shadow_reg[idx_reg[VI_W-1:0]];
        end
        if (cmd.load_byte)
        begin
            out_kind_reg   <= KIND_BYTE;
            out_addr_reg   <= byte_addr;
            out_data_reg   <= {24'd0, rd_reg};
            out_status_reg <= ST_DATA_OK;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.load_vec)
        begin
            out_kind_reg   <= KIND_VEC;
            out_addr_reg   <= VEC_ADDR;
            out_data_reg   <= ~acc_reg + 32'd1;
            out_status_reg <= ST_DATA_OK;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.load_status)
        begin
            out_kind_reg   <= KIND_STATUS;
            out_addr_reg   <= '0;
            out_data_reg   <= '0;
            out_status_reg <= cmd.status;
            out_last_reg   <= 1'b1;
        end
    end

endmodule

[rtl/ihex_ctrl.sv]
// Controller of the HEX record loader: receive, judge and emit sequencing.
// Depends on ihex_pkg; drives ihex_dpath through ihex_cmd_t.
module ihex_ctrl
    import ihex_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_last,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ihex_sts_t sts,
    output ihex_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_RECV,
        S_JUDGE,
        S_BYTE,
        S_BWAIT,
        S_VSUM,
        S_VEC,
        S_VWAIT,
        S_SWAIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_RECV);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.status     = ST_DATA_OK;
        unique case (state_reg)
            S_RECV:
            begin
                cmd.take = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                cmd.judge = 1'b1;
                if (sts.malformed)
                begin
                    cmd.load_status = 1'b1;
                    cmd.status      = ST_MALFORMED;
                end
                else if (sts.sum_bad)
                begin
                    cmd.load_status = 1'b1;
                    cmd.status      = ST_SUM_BAD;
                end
                else
                begin
                    unique case (sts.rec_type)
                        REC_DATA:
                        begin
                            cmd.load_status = sts.len_zero;
                            cmd.status      = ST_DATA_OK;
                        end
                        REC_EOF:
                        begin
                            cmd.load_status = 1'b0;
                        end
                        REC_EXT_SEG, REC_EXT_LIN:
                        begin
                            cmd.set_offset  = sts.len_two;
                            cmd.load_status = 1'b1;
                            cmd.status      = ST_OTHER_OK;
                        end
                        default:
                        begin
                            cmd.load_status = 1'b1;
                            cmd.status      = ST_OTHER_OK;
                        end
                    endcase
                end
                if (cmd.load_status)
                begin
                    state_next     = S_SWAIT;
                    out_valid_next = 1'b1;
                end
                else if (sts.rec_type == REC_EOF)
                begin
                    state_next = S_VSUM;
                end
                else
                begin
                    state_next = S_BYTE;
                end
            end
            S_BYTE:
            begin
                cmd.load_byte  = 1'b1;
                state_next     = S_BWAIT;
                out_valid_next = 1'b1;
            end
            S_BWAIT:
            begin
                if (out_ready)
                begin
                    if (sts.byte_done)
                    begin
                        cmd.load_status = 1'b1;
                        cmd.status      = ST_DATA_OK;
                        state_next      = S_SWAIT;
                    end
                    else
                    begin
                        cmd.idx_inc    = 1'b1;
                        state_next     = S_BYTE;
                        out_valid_next = 1'b0;
                    end
                end
            end
            S_VSUM:
            begin
                cmd.acc_add = 1'b1;
                cmd.idx_inc = !sts.vsum_done;
                if (sts.vsum_done)
                begin
                    state_next = S_VEC;
                end
            end
            S_VEC:
            begin
                cmd.load_vec   = 1'b1;
                state_next     = S_VWAIT;
                out_valid_next = 1'b1;
            end
            S_VWAIT:
            begin
                if (out_ready)
                begin
                    cmd.load_status = 1'b1;
                    cmd.status      = ST_EOF;
                    state_next      = S_SWAIT;
                end
            end
            S_SWAIT:
            begin
                if (out_ready)
                begin
                    state_next     = S_RECV;
                    out_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next     = S_RECV;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RECV;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/intel_hex_record_loader_unit.sv]
// Top level of the HEX record loader: stream ports, controller and datapath.
// Depends on ihex_pkg, ihex_ctrl and ihex_dpath.
//
// Takes the binary bytes of HEX records (count, address high, address low,
// type, data bytes, checksum), one byte per input transaction, with s_tlast
// on the checksum byte. Bytes without s_tlast are absorbed without stalling
// the input and produce nothing. After the checksum byte the record is
// judged. A malformed record (byte total not count + 5, or count above
// MAX_DATA) yields only status 4; a bad checksum yields only status 3. A
// good data record yields one byte write per data byte at offset + address
// + i, then status 0. Extended segment / linear records with count 2 set the
// offset, status 1; other types give status 1. End of file sums the vector
// shadow (bytes 0 .. 4*VECTOR_WORDS-1 of the written image, zero at reset)
// and writes its negation at address 4*VECTOR_WORDS, then status 2. The
// status result always carries tlast. Timing: one item is handled at a
// time; s_tready is low from the checksum byte until the status transaction
// completes. Each data byte is read from the buffer into the shared output
// register, then held there until its output transaction completes. End of
// file goes through the judge state, sums the shadow words one at a time in
// the single shadow adder, then loads the checksum word and performs one
// output transaction for it and one for the status.
module intel_hex_record_loader_unit
    import ihex_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] record_byte
    input  logic               s_tlast,   // end_of_record
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [31:0] write_address, [63:32] write_data,
                                          // [66:64] status, [71:67] zero
    output logic [1:0]         m_tuser,   // [1:0] kind
    output logic               m_tlast    // last result of the record
);

    ihex_cmd_t   cmd;
    ihex_sts_t   sts;
    kind_t       out_kind;
    logic [31:0] out_addr;
    logic [31:0] out_data;
    status_t     out_status;
    logic        out_last;

    ihex_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ihex_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .out_kind   (out_kind),
        .out_addr   (out_addr),
        .out_data   (out_data),
        .out_status (out_status),
        .out_last   (out_last)
    );

    // pack result fields, first field lowest
    assign m_tdata = {5'd0, out_status, out_data, out_addr};
    assign m_tuser = out_kind;
    assign m_tlast = out_last;

endmodule

[rtl/ihex_chk.sv]
// Port-level checker for the HEX record loader, bound to the top level.
// Depends on ihex_pkg and intel_hex_record_loader_unit.
module ihex_chk
    import ihex_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [1:0]         m_tuser,
    input logic               m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one record at a time: input side closed while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input open while result pending");

    // tlast marks exactly the status result
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
        else $error("tlast does not match status kind");

    // bytes inside a record never stall the input
    a_absorb: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> s_tready && !m_tvalid)
        else $error("mid-record byte produced output or stall");

    // after the status transaction the block reopens its input
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("input not reopened after status");

endmodule

bind intel_hex_record_loader_unit ihex_chk u_chk (.*);

[dv/testbench.sv]
// Self-checking testbench for intel_hex_record_loader_unit: random HEX record
// streams in, writes and record status checked against a decoder model in a scoreboard.
// Depends on rtl/ihex_pkg.sv and the loader RTL; nothing else.
`timescale 1ns / 100ps

import ihex_pkg::*;

// One expected loader output transaction.
typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [31:0] data;
    status_t     status;
    logic        last;
} loader_result_t;

class hex_scoreboard;
    // decoder state: current record, load offset and vector-table shadow
    logic [5:0]     rec_pos;
    logic [7:0]     rec_len;
    logic [15:0]    rec_base;
    logic [7:0]     rec_kind;
    logic [7:0]     rec_sum;
    logic [7:0]     data_bytes [MAX_DATA];
    logic [31:0]    load_offset;
    logic [31:0]    vec_shadow [VECTOR_WORDS];
    loader_result_t pending_q [$];
    int             errors;

    function new();
        rec_pos     = '0;
        rec_len     = '0;
        rec_base    = '0;
        rec_kind    = '0;
        rec_sum     = '0;
        load_offset = '0;
        errors      = 0;
        foreach (data_bytes[i])
            data_bytes[i] = '0;
        foreach (vec_shadow[i])
            vec_shadow[i] = '0;
    endfunction

    function void add_result(kind_t k, logic [31:0] a, logic [31:0] d, status_t s, logic l);
        loader_result_t r;
        r.kind    = k;
        r.addr    = a;
        r.data    = d;
        r.status  = s;
        r.last    = l;
        pending_q = {pending_q, r};
    endfunction

    function int outstanding();
        return pending_q.size();
    endfunction

    // Accepted input transaction: absorb the byte, judge the record on its end mark.
    function void note_byte(logic [7:0] b, logic eor);
        int          total;
        logic [31:0] a;
        logic [31:0] vsum;
        rec_sum = rec_sum + b;
        if (!eor)
        begin
            unique case (rec_pos)
                6'd0: rec_len = b;
                6'd1: rec_base[15:8] = b;
                6'd2: rec_base[7:0] = b;
                6'd3: rec_kind = b;
                default:
                    if (int'(rec_pos) - 4 < MAX_DATA)
                        data_bytes[int'(rec_pos) - 4] = b;
            endcase
            if (rec_pos != POS_MAX)
                rec_pos = rec_pos + 6'd1;
            return;
        end
        total = int'(rec_pos) + 1;
        if (total != int'(rec_len) + 5 || int'(rec_len) > MAX_DATA)
            add_result(KIND_STATUS, '0, '0, ST_MALFORMED, 1'b1);
        else if (rec_sum != 8'h00)
            add_result(KIND_STATUS, '0, '0, ST_SUM_BAD, 1'b1);
        else
        begin
            unique case (rec_kind)
                REC_DATA:
                begin
                    for (int i = 0; i < int'(rec_len); i++)
                    begin
                        a = load_offset + 32'(rec_base) + 32'(i);
                        // keep the vector-table shadow in step with the image
                        if ((a >> 2) < VECTOR_WORDS)
                            vec_shadow[a >> 2][8 * a[1:0] +: 8] = data_bytes[i];
                        add_result(KIND_BYTE, a, 32'(data_bytes[i]), ST_DATA_OK, 1'b0);
                    end
                    add_result(KIND_STATUS, '0, '0, ST_DATA_OK, 1'b1);
                end
                REC_EOF:
                begin
                    vsum = '0;
                    foreach (vec_shadow[i])
                        vsum = vsum + vec_shadow[i];
                    add_result(KIND_VEC, VEC_ADDR, ~vsum + 32'd1, ST_DATA_OK, 1'b0);
                    add_result(KIND_STATUS, '0, '0, ST_EOF, 1'b1);
                end
                REC_EXT_SEG, REC_EXT_LIN:
                begin
                    // only a two-byte payload moves the offset
                    if (rec_len == 8'd2)
                    begin
                        if (rec_kind == REC_EXT_SEG)
                            load_offset = {12'h000, data_bytes[0], data_bytes[1], 4'h0};
                        else
                            load_offset = {data_bytes[0], data_bytes[1], 16'h0000};
                    end
                    add_result(KIND_STATUS, '0, '0, ST_OTHER_OK, 1'b1);
                end
                default:
                    add_result(KIND_STATUS, '0, '0, ST_OTHER_OK, 1'b1);
            endcase
        end
        rec_pos = '0;
        rec_sum = '0;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // Accepted output transaction: compare against the oldest expectation.
    function void check_result(logic [1:0] kind, logic [31:0] addr, logic [31:0] data,
                               logic [2:0] status, logic last);
        loader_result_t want;
        if (pending_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d addr 0x%0h",
                     $time, kind, addr);
            $display("    data 0x%0h status %0d last %0d", data, status, last);
            return;
        end
        want = pending_q.pop_front();
        compare_field("kind", 32'(want.kind), 32'(kind));
        compare_field("write_address", want.addr, addr);
        compare_field("write_data", want.data, data);
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("last", 32'(want.last), 32'(last));
    endfunction
endclass

module testbench;

    localparam int ITEM_TARGET = 220;    // least number of input transactions in all, directed bytes included
    localparam int STALL_LIMIT = 2000;   // cycles without any transaction before giving up

    // start address record types, no effect on the image
    localparam logic [7:0] REC_START_SEG = 8'h03;
    localparam logic [7:0] REC_START_LIN = 8'h05;

    // record shapes used by the random part; the first pass walks every one in order
    typedef enum int {
        RC_DATA_FULL,
        RC_DATA,
        RC_EOF,
        RC_SEG,
        RC_LIN,
        RC_START,
        RC_ODD_TYPE,
        RC_OFS_BADLEN,
        RC_BAD_SUM,
        RC_OVERSIZE,
        RC_MISCOUNT,
        RC_SHORT,
        RC_RUNAWAY,
        RC_COUNT
    } rec_case_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    hex_scoreboard sb = new();

    logic [7:0] payload [$];    // data field of the next record to send
    bit         quiet;          // no idling on either side while set
    int         items_sent;
    int         stall_cycles = 0;

    intel_hex_record_loader_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sink side: ready drops in about a quarter of the cycles, except in the quiet stretch.
    always @(posedge clk)
    begin
        m_tready <= rst_n && (quiet || $urandom_range(0, 99) >= 26);
    end

    // Monitor: both sides are sampled at the edge, before any of this edge's updates land.
    // The input transaction goes first; a record's results only start after its checksum
    // byte was taken, so they never share an edge with it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[66:64],
                                m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One input transaction, with random idle cycles ahead of it. Valid stays high
    // across back-to-back bytes: only one assignment per edge.
    task automatic send_byte(input logic [7:0] b, input logic eor);
        while (!quiet && $urandom_range(0, 99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eor;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic fill_payload(input int n);
        payload.delete();
        repeat (n)
            payload = {payload, 8'($urandom_range(0, 255))};
    endtask

    // count, address, type, payload, checksum; skew != 0 corrupts the checksum
    task automatic send_record(input logic [7:0] count, input logic [15:0] addr,
                               input logic [7:0] rtype, input logic [7:0] skew);
        logic [7:0] body [$];
        logic [7:0] csum;
        body = {body, count};
        body = {body, addr[15:8]};
        body = {body, addr[7:0]};
        body = {body, rtype};
        foreach (payload[i])
            body = {body, payload[i]};
        csum = 8'h00;
        foreach (body[i])
            csum = csum - body[i];
        body = {body, 8'(csum + skew)};
        foreach (body[i])
            send_byte(body[i], i == body.size() - 1);
    endtask

    initial
    begin
        rec_case_t   pick;
        int          n_rec;
        int          n;
        int          c;
        int          r;
        logic [15:0] addr;
        logic [7:0]  rtype;

        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tlast    <= 1'b0;
        m_tready   <= 1'b0;
        quiet      = 1'b0;
        items_sent = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        // data record at address zero: an all-ones byte lands in the vector shadow
        payload.delete();
        payload = {payload, 8'hFF};
        payload = {payload, 8'h00};
        send_record(8'd2, 16'h0000, REC_DATA, 8'h00);
        // end of file sees a nonzero shadow word
        payload.delete();
        send_record(8'd0, 16'h0000, REC_EOF, 8'h00);
        // a lone end-marked byte is a short record
        send_byte(8'h00, 1'b1);
        // start record with a broken checksum
        send_record(8'd0, 16'hFFFF, REC_START_SEG, 8'h01);
        // linear offset at its top value, so the next full record can wrap past 2^32
        payload.delete();
        payload = {payload, 8'hFF};
        payload = {payload, 8'hFF};
        send_record(8'd2, 16'h0000, REC_EXT_LIN, 8'h00);

        // Random part: mostly well-formed records with random content, some broken ones.
        n_rec = 0;
        while (n_rec < int'(RC_COUNT) || items_sent < ITEM_TARGET)
        begin
            if (n_rec < int'(RC_COUNT))
                pick = rec_case_t'(n_rec);
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)      pick = RC_DATA;
                else if (r < 50) pick = RC_DATA_FULL;
                else if (r < 58) pick = RC_EOF;
                else if (r < 63) pick = RC_SEG;
                else if (r < 70) pick = RC_LIN;
                else if (r < 73) pick = RC_START;
                else if (r < 75) pick = RC_ODD_TYPE;
                else if (r < 77) pick = RC_OFS_BADLEN;
                else if (r < 83) pick = RC_BAD_SUM;
                else if (r < 86) pick = RC_OVERSIZE;
                else if (r < 91) pick = RC_MISCOUNT;
                else if (r < 96) pick = RC_SHORT;
                else             pick = RC_RUNAWAY;
            end
            quiet = (n_rec >= 4 && n_rec < 12);    // back-to-back stretch on both sides
            unique case (pick)
                RC_DATA_FULL:
                begin
                    // largest record; near the top of a page it wraps into the low image
                    addr = ($urandom_range(0, 1) == 0) ? 16'hFFF0 : 16'($urandom);
                    fill_payload(MAX_DATA);
                    send_record(8'(MAX_DATA), addr, REC_DATA, 8'h00);
                end
                RC_DATA:
                begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_DATA)
                                                    : $urandom_range(1, 6);
                    // with no offset, aim half the records at the vector table
                    if (sb.load_offset == 32'h0 && $urandom_range(0, 1) == 0)
                        addr = 16'($urandom_range(0, 4 * VECTOR_WORDS - 1));
                    else
                        addr = 16'($urandom);
                    fill_payload(n);
                    send_record(8'(n), addr, REC_DATA, 8'h00);
                end
                RC_EOF:
                begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
                    fill_payload(n);
                    send_record(8'(n), 16'($urandom), REC_EOF, 8'h00);
                end
                RC_SEG, RC_LIN:
                begin
                    payload.delete();
                    r = $urandom_range(0, 3);
                    if (r < 2)
                    begin
                        payload = {payload, 8'h00};
                        payload = {payload, 8'h00};
                    end
                    else if (r == 2 && pick == RC_LIN)
                    begin
                        payload = {payload, 8'hFF};
                        payload = {payload, 8'hFF};
                    end
                    else
                        fill_payload(2);
                    rtype = (pick == RC_SEG) ? REC_EXT_SEG : REC_EXT_LIN;
                    send_record(8'd2, 16'($urandom), rtype, 8'h00);
                end
                RC_START:
                begin
                    n = ($urandom_range(0, 1) == 0) ? 4 : $urandom_range(0, 3);
                    fill_payload(n);
                    rtype = ($urandom_range(0, 1) == 0) ? REC_START_SEG : REC_START_LIN;
                    send_record(8'(n), 16'($urandom), rtype, 8'h00);
                end
                RC_ODD_TYPE:
                begin
                    n = $urandom_range(0, 4);
                    fill_payload(n);
                    rtype = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom_range(6, 254));
                    send_record(8'(n), 16'($urandom), rtype, 8'h00);
                end
                RC_OFS_BADLEN:
                begin
                    // offset record with a payload other than two bytes leaves the offset alone
                    n = $urandom_range(0, 4);
                    if (n == 2)
                        n = 3;
                    fill_payload(n);
                    rtype = ($urandom_range(0, 1) == 0) ? REC_EXT_SEG : REC_EXT_LIN;
                    send_record(8'(n), 16'($urandom), rtype, 8'h00);
                end
                RC_BAD_SUM:
                begin
                    n = $urandom_range(0, 4);
                    fill_payload(n);
                    r = $urandom_range(0, 3);
                    rtype = (r == 0) ? REC_DATA : (r == 1) ? REC_EOF :
                            (r == 2) ? REC_EXT_LIN : REC_EXT_SEG;
                    send_record(8'(n), 16'($urandom), rtype, 8'($urandom_range(1, 255)));
                end
                RC_OVERSIZE:
                begin
                    // byte total agrees with the count, but the count is over the limit
                    n = $urandom_range(MAX_DATA + 1, MAX_DATA + 4);
                    fill_payload(n);
                    send_record(8'(n), 16'($urandom), REC_DATA, 8'h00);
                end
                RC_MISCOUNT:
                begin
                    c = $urandom_range(0, MAX_DATA);
                    n = $urandom_range(0, MAX_DATA + 8);
                    if (n == c)
                        n = c + 1;
                    fill_payload(n);
                    send_record(8'(c), 16'($urandom), REC_DATA, 8'h00);
                end
                RC_SHORT:
                begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        send_byte(8'($urandom_range(0, 255)), i == n - 1);
                end
                default:
                begin
                    // runaway record: the byte counter saturates before the end mark
                    n = $urandom_range(64, 72);
                    for (int i = 0; i < n; i++)
                        send_byte(8'($urandom_range(0, 255)), i == n - 1);
                end
            endcase
            n_rec++;
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        // let the monitor take the last byte, drain, then give a stray late result time
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (VECTOR_WORDS + 40)
            @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
